### hw/rtl/mwr_pkg.sv
// Shared types and constants for the matrix wavefront recurrence core.
// No dependencies; imported by mwr_front, mwr_back and the top level.
package mwr_pkg;

   localparam int ElemW      = 32;
   localparam int RowsW      = 16;
   localparam int ColsW      = 11;
   localparam int CsrIndexW  = 2;
   localparam int CsrDataW   = 16;
   localparam int MaxColsDef = 1024;
   localparam int QueueDepth = 2;

   localparam logic [RowsW-1:0] RowsReset = RowsW'(64);
   localparam logic [ColsW-1:0] ColsReset = ColsW'(64);

   // Register map of the configuration port.
   localparam logic [CsrIndexW-1:0] CsrNumRows = CsrIndexW'(0);
   localparam logic [CsrIndexW-1:0] CsrNumCols = CsrIndexW'(1);

   // Per-element classification made by the front end.
   typedef struct packed {
      logic pass;   // row 0 or column 0: element goes out unchanged
      logic last;   // final element of the matrix
   } tag_type;

   localparam int TagW = $bits(tag_type);

endpackage

### hw/rtl/mwr_queue.sv
// Small synchronous FIFO with full/empty flags.
// Depends on nothing; used between front and back and on the result side.
module mwr_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CntW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### hw/rtl/mwr_front.sv
// Front end: configuration registers, row/column tracking and element tagging.
// Depends on mwr_pkg; feeds the work queue in front of mwr_back.
module mwr_front #(
   parameter int MAX_COLS = mwr_pkg::MaxColsDef
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_push,
   input  logic signed [mwr_pkg::ElemW-1:0]      req_elem_in,
   output logic                                  req_full,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [mwr_pkg::CsrIndexW-1:0]         csr_index,
   input  logic [mwr_pkg::CsrDataW-1:0]          csr_data,
   input  logic                                  q_full,
   output logic                                  q_push,
   output logic [mwr_pkg::ElemW-1:0]             q_elem,
   output logic [$clog2(MAX_COLS)-1:0]           q_col,
   output mwr_pkg::tag_type                      q_tag
);
   import mwr_pkg::*;

   localparam int ColW = $clog2(MAX_COLS);
   localparam int CntW = $clog2(MAX_COLS + 1);
   localparam int EffW = (CntW > ColsW) ? CntW : ColsW;

   logic [RowsW-1:0] num_rows_ff, num_rows_in;
   logic [ColsW-1:0] num_cols_ff, num_cols_in;
   logic [ColW-1:0]  col_ff, col_in;
   logic [RowsW-1:0] row_ff, row_in;

   logic [EffW-1:0]  cols_ext, cols_eff, col_next;
   logic [RowsW:0]   rows_eff, row_next;
   logic             col_wrap, row_wrap;

   assign csr_ready = 1'b1;
   assign req_full  = q_full;
   assign q_push    = req_push && !q_full;
   assign q_elem    = req_elem_in;
   assign q_col     = col_ff;

   always_comb begin
      cols_ext = EffW'(num_cols_ff);
      if (cols_ext == '0) begin
         cols_eff = EffW'(1);
      end else if (cols_ext > EffW'(MAX_COLS)) begin
         cols_eff = EffW'(MAX_COLS);
      end else begin
         cols_eff = cols_ext;
      end
      rows_eff = (num_rows_ff == '0) ? (RowsW+1)'(1) : {1'b0, num_rows_ff};
      col_next = EffW'(col_ff) + EffW'(1);
      row_next = {1'b0, row_ff} + (RowsW+1)'(1);
      col_wrap = (col_next >= cols_eff);
      row_wrap = (row_next >= rows_eff);

      q_tag.pass = (row_ff == '0) || (col_ff == '0);
      q_tag.last = col_wrap && row_wrap;

      col_in = col_ff;
      row_in = row_ff;
      if (q_push) begin
         if (col_wrap) begin
            col_in = '0;
            row_in = row_wrap ? '0 : row_next[RowsW-1:0];
         end else begin
            col_in = col_next[ColW-1:0];
         end
      end

      num_rows_in = num_rows_ff;
      num_cols_in = num_cols_ff;
      if (csr_valid) begin
         case (csr_index)
            CsrNumRows: num_rows_in = csr_data[RowsW-1:0];
            CsrNumCols: num_cols_in = csr_data[ColsW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_rows_ff <= RowsReset;
         num_cols_ff <= ColsReset;
         col_ff      <= '0;
         row_ff      <= '0;
      end else begin
         num_rows_ff <= num_rows_in;
         num_cols_ff <= num_cols_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
      end
   end

endmodule

### hw/rtl/mwr_back.sv
// Back end: line buffer read stage and a combinational three-neighbor sum behind it.
// Depends on mwr_pkg; pulls from the work queue, pushes to the result queue.
module mwr_back #(
   parameter int MAX_COLS = mwr_pkg::MaxColsDef
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_empty,
   input  logic [mwr_pkg::ElemW-1:0]     q_elem,
   input  logic [$clog2(MAX_COLS)-1:0]   q_col,
   input  mwr_pkg::tag_type              q_tag,
   output logic                          q_pop,
   input  logic                          o_full,
   output logic                          o_push,
   output logic [mwr_pkg::ElemW-1:0]     o_elem,
   output logic                          o_last
);
   import mwr_pkg::*;

   localparam int ColW = $clog2(MAX_COLS);

   // Previous updated row; user must get each entry written before use; unchecked.
   logic [ElemW-1:0] line_mem [MAX_COLS];

   logic             s1_valid_ff, s1_valid_in;
   logic [ElemW-1:0] s1_elem_ff;
   logic [ColW-1:0]  s1_col_ff;
   tag_type          s1_tag_ff;
   logic [ElemW-1:0] upper_ff;
   logic [ElemW-1:0] left_ff, left_in;
   logic [ElemW-1:0] upleft_ff, upleft_in;
   logic [ElemW-1:0] result;
   logic             fire, load;

   assign fire   = s1_valid_ff && !o_full;
   assign load   = !q_empty && (!s1_valid_ff || fire);
   assign q_pop  = load;
   assign o_push = fire;
   assign o_elem = result;
   assign o_last = s1_tag_ff.last;

   always_comb begin
      result      = s1_tag_ff.pass ? s1_elem_ff : (upleft_ff + upper_ff + left_ff);
      left_in     = fire ? result   : left_ff;
      upleft_in   = fire ? upper_ff : upleft_ff;
      s1_valid_in = load || (s1_valid_ff && !fire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         left_ff     <= '0;
         upleft_ff   <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         left_ff     <= left_in;
         upleft_ff   <= upleft_in;
      end
   end

   // Read of the next column overlaps the write of the current one; the
   // addresses only coincide for single-column matrices, where upper is unused.
   always_ff @(posedge clock) begin
      if (fire) begin
         line_mem[s1_col_ff] <= result;
      end
      if (load) begin
         upper_ff   <= line_mem[q_col];
         s1_elem_ff <= q_elem;
         s1_col_ff  <= q_col;
         s1_tag_ff  <= q_tag;
      end
   end

endmodule

### hw/rtl/matrix_wavefront_recurrence_core.sv
// Top level of the matrix wavefront recurrence core.
// Depends on mwr_pkg, mwr_front, mwr_queue and mwr_back.
//
//   channel   ports                                  transaction when
//   -------   ------------------------------------   -----------------------
//   req       req_push req_full req_elem_in          req_push && !req_full
//   rsp       rsp_pop rsp_empty rsp_elem_out         rsp_pop && !rsp_empty
//             rsp_is_last
//   csr       csr_valid csr_ready csr_index          csr_valid && csr_ready
//             csr_data
//
// One element per cycle sustained while the rsp side pops; an element passes
// the work queue, the line buffer read register and the result queue; the
// three-input add is combinational. Reset clears position, neighbors and
// queues; the line buffer is not cleared. A stalled rsp side fills the result
// queue, then the read stage, then the work queue, then raises req_full.
module matrix_wavefront_recurrence_core #(
   parameter int MAX_COLS = mwr_pkg::MaxColsDef
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic signed [mwr_pkg::ElemW-1:0]  req_elem_in,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic signed [mwr_pkg::ElemW-1:0]  rsp_elem_out,
   output logic                              rsp_is_last,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [mwr_pkg::CsrIndexW-1:0]     csr_index,
   input  logic [mwr_pkg::CsrDataW-1:0]      csr_data
);
   import mwr_pkg::*;

   localparam int ColW = $clog2(MAX_COLS);
   localparam int WqW  = ElemW + ColW + TagW;
   localparam int RqW  = ElemW + 1;

   logic             f_push, wq_full, wq_empty, wq_pop;
   logic [ElemW-1:0] f_elem, b_elem;
   logic [ColW-1:0]  f_col, b_col;
   tag_type          f_tag, b_tag;
   logic [WqW-1:0]   wq_out;
   logic             o_push, o_full, o_last;
   logic [ElemW-1:0] o_elem;
   logic [RqW-1:0]   rq_out;

   mwr_front #(.MAX_COLS(MAX_COLS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_elem_in (req_elem_in),
      .req_full    (req_full),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .q_full      (wq_full),
      .q_push      (f_push),
      .q_elem      (f_elem),
      .q_col       (f_col),
      .q_tag       (f_tag)
   );

   mwr_queue #(.WIDTH(WqW), .DEPTH(QueueDepth)) u_work_q (
      .clock     (clock),
      .reset     (reset),
      .push      (f_push),
      .push_data ({f_elem, f_col, f_tag}),
      .full      (wq_full),
      .pop       (wq_pop),
      .pop_data  (wq_out),
      .empty     (wq_empty)
   );

   assign {b_elem, b_col, b_tag} = wq_out;

   mwr_back #(.MAX_COLS(MAX_COLS)) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (wq_empty),
      .q_elem  (b_elem),
      .q_col   (b_col),
      .q_tag   (b_tag),
      .q_pop   (wq_pop),
      .o_full  (o_full),
      .o_push  (o_push),
      .o_elem  (o_elem),
      .o_last  (o_last)
   );

   mwr_queue #(.WIDTH(RqW), .DEPTH(QueueDepth)) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (o_push),
      .push_data ({o_last, o_elem}),
      .full      (o_full),
      .pop       (rsp_pop),
      .pop_data  (rq_out),
      .empty     (rsp_empty)
   );

   assign rsp_is_last  = rq_out[RqW-1];
   assign rsp_elem_out = rq_out[ElemW-1:0];

endmodule

### tb/sv/tb_matrix_wavefront_recurrence_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for matrix_wavefront_recurrence_core: streams matrices of
// varying sizes under random handshake pressure and predicts every updated element.
// Depends on mwr_pkg and the core RTL only.
module tb_matrix_wavefront_recurrence_core;
   import mwr_pkg::*;

   localparam int                   MaxCols    = MaxColsDef;
   localparam int unsigned          CycleLimit = 400000;
   localparam int                   ReportMax  = 10;
   // index outside the register map; a write there must change nothing
   localparam logic [CsrIndexW-1:0] CsrSpare   = CsrIndexW'(3);

   typedef struct {
      logic [ElemW-1:0] elem;
      logic             last;
   } elem_result_type;

   // Tracks matrix position, neighbors and line buffer; holds awaited elements.
   class wavefront_tracker_type;
      logic [ElemW-1:0] line_buf [MaxCols];
      bit               line_set [MaxCols];
      logic [ElemW-1:0] left_val;
      logic [ElemW-1:0] upleft_val;
      logic [9:0]       col_pos;
      logic [RowsW-1:0] row_pos;
      logic [RowsW-1:0] rows_reg;
      logic [ColsW-1:0] cols_reg;
      elem_result_type  awaited[$];
      int               mismatches;

      function new();
         foreach (line_buf[j]) begin
            line_buf[j] = '0;
            line_set[j] = 1'b0;
         end
         left_val   = '0;
         upleft_val = '0;
         col_pos    = '0;
         row_pos    = '0;
         rows_reg   = RowsReset;
         cols_reg   = ColsReset;
         mismatches = 0;
      endfunction

      function int unsigned rows_eff();
         return (rows_reg == 0) ? 1 : rows_reg;
      endfunction

      function int unsigned cols_of(logic [ColsW-1:0] raw);
         if (raw == 0) return 1;
         if (raw > MaxCols) return MaxCols;
         return raw;
      endfunction

      function void write_reg(logic [CsrIndexW-1:0] idx, logic [CsrDataW-1:0] data);
         case (idx)
            CsrNumRows: rows_reg = data[RowsW-1:0];
            CsrNumCols: cols_reg = data[ColsW-1:0];
            default: ;
         endcase
      endfunction

      // Rest of the current row must only read line buffer entries already written.
      function bit cols_safe(logic [ColsW-1:0] raw);
         int unsigned stop;
         int unsigned j;
         if (row_pos == 0) return 1'b1;
         stop = cols_of(raw);
         if (stop <= col_pos) stop = col_pos + 1;
         for (j = col_pos; j < stop && j < MaxCols; j++)
            if (!line_set[j]) return 1'b0;
         return 1'b1;
      endfunction

      function int unsigned left_in_matrix();
         int unsigned cols;
         int unsigned rest;
         cols = cols_of(cols_reg);
         rest = (col_pos >= cols) ? 1 : cols - col_pos;
         if (row_pos + 1 < rows_eff()) rest += (rows_eff() - row_pos - 1) * cols;
         return rest;
      endfunction

      function void take_element(logic [ElemW-1:0] elem);
         int unsigned      cols;
         int unsigned      c;
         int unsigned      r;
         logic [ElemW-1:0] upper;
         logic [ElemW-1:0] sum;
         elem_result_type  want;
         cols  = cols_of(cols_reg);
         c     = col_pos;
         r     = row_pos;
         upper = '0;
         if (c < MaxCols) upper = line_buf[c];
         if (r == 0 || c == 0) sum = elem;
         else sum = upleft_val + upper + left_val;
         upleft_val = upper;
         left_val   = sum;
         if (c < MaxCols) begin
            line_buf[c] = sum;
            line_set[c] = 1'b1;
         end
         want.elem = sum;
         want.last = 1'b0;
         if (c + 1 >= cols) begin
            col_pos = '0;
            if (r + 1 >= rows_eff()) begin
               row_pos   = '0;
               want.last = 1'b1;
            end else begin
               row_pos = RowsW'(r + 1);
            end
         end else begin
            col_pos = 10'(c + 1);
         end
         awaited.push_back(want);
      endfunction

      function void note_error(string msg);
         mismatches++;
         if (mismatches <= ReportMax) $display("MISMATCH: %s", msg);
      endfunction

      function void check_output(logic [ElemW-1:0] elem, logic last);
         elem_result_type want;
         if (awaited.size() == 0) begin
            note_error($sformatf("unexpected element: elem_out=%h is_last=%b", elem, last));
            return;
         end
         want = awaited.pop_front();
         if (elem !== want.elem || last !== want.last)
            note_error($sformatf("elem_out exp %h got %h, is_last exp %b got %b",
                                 want.elem, elem, want.last, last));
      endfunction
   endclass

   logic                        clock = 1'b0;
   logic                        reset;
   logic                        req_push;
   logic                        req_full;
   logic signed [ElemW-1:0]     req_elem_in;
   logic                        rsp_empty;
   logic                        rsp_pop;
   logic signed [ElemW-1:0]     rsp_elem_out;
   logic                        rsp_is_last;
   logic                        csr_valid;
   logic                        csr_ready;
   logic [CsrIndexW-1:0]        csr_index;
   logic [CsrDataW-1:0]         csr_data;

   int                          send_pct;
   int                          recv_pct;
   int unsigned                 cycle_count = 0;
   wavefront_tracker_type       tracker;

   matrix_wavefront_recurrence_core i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_elem_in  (req_elem_in),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_elem_out (rsp_elem_out),
      .rsp_is_last  (rsp_is_last),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Result side: random pop, checked on each accepted transaction.
   always @(negedge clock) begin
      rsp_pop <= !reset && ($urandom_range(99) >= recv_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) tracker.check_output(rsp_elem_out, rsp_is_last);
   end

   function automatic logic [ElemW-1:0] random_elem();
      case ($urandom_range(9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return '0;
         3: return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [CsrDataW-1:0] pick_rows();
      case ($urandom_range(19))
         0: return '0;
         1: return '1;
         2: return CsrDataW'($urandom);
         default: return CsrDataW'($urandom_range(1, 8));
      endcase
   endfunction

   // Upper data bits beyond the register width are random; the core must drop them.
   function automatic logic [CsrDataW-1:0] pick_cols();
      logic [CsrDataW-1:0] data;
      data = CsrDataW'($urandom);
      case ($urandom_range(19))
         0: data[ColsW-1:0] = '0;
         1: ;
         2: data[ColsW-1:0] = ColsW'(MaxCols);
         3: data[ColsW-1:0] = '1;
         default: data[ColsW-1:0] = ColsW'($urandom_range(1, 12));
      endcase
      return data;
   endfunction

   // Entered and left at a falling edge; push stays high for back-to-back items.
   task automatic send_elem(input logic [ElemW-1:0] value);
      while ($urandom_range(99) < send_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push    <= 1'b1;
      req_elem_in <= value;
      do @(posedge clock); while (req_full);
      tracker.take_element(value);
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [CsrIndexW-1:0] idx, input logic [CsrDataW-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      tracker.write_reg(idx, data);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic drain();
      req_push <= 1'b0;
      while (tracker.awaited.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic configure(input logic [CsrDataW-1:0] rows_data,
                            input logic [CsrDataW-1:0] cols_data);
      if (!tracker.cols_safe(cols_data[ColsW-1:0])) cols_data[ColsW-1:0] = tracker.cols_reg;
      write_csr(CsrNumRows, rows_data);
      write_csr(CsrNumCols, cols_data);
   endtask

   // Mostly whole matrices from the current position, sometimes a cut-off stretch.
   task automatic run_segment(inout int sent);
      int unsigned span;
      int unsigned count;
      drain();
      configure(pick_rows(), pick_cols());
      if ($urandom_range(7) == 0) write_csr(CsrSpare, CsrDataW'($urandom));
      span  = tracker.rows_eff() * tracker.cols_of(tracker.cols_reg);
      count = tracker.left_in_matrix();
      if (span <= 96 && count <= 96 && $urandom_range(4) != 0)
         count += span * $urandom_range(0, 2);
      else
         count = $urandom_range(5, 60);
      repeat (count) send_elem(random_elem());
      sent += count;
   endtask

   task automatic run_phase(input int s_pct, input int r_pct, input int target);
      int sent;
      send_pct = s_pct;
      recv_pct = r_pct;
      sent     = 0;
      while (sent < target) run_segment(sent);
   endtask

   initial begin
      reset       = 1'b1;
      req_push    = 1'b0;
      req_elem_in = '0;
      rsp_pop     = 1'b0;
      csr_valid   = 1'b0;
      csr_index   = '0;
      csr_data    = '0;
      send_pct    = 14;
      recv_pct    = 76;
      tracker     = new();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset sizes: start of a 64x64 matrix
      send_elem(32'h7FFF_FFFF);
      send_elem(32'h8000_0000);
      send_elem('1);
      drain();
      // column index now past the last column: next element closes row 0
      configure(CsrDataW'(3), CsrDataW'(3));
      send_elem('0);
      send_elem(32'h7FFF_FFFF);
      send_elem(32'h1234_5678);
      send_elem('0);
      send_elem(32'h8000_0000);
      send_elem(32'h7FFF_FFFF);
      send_elem('1);
      drain();
      // zero sizes act as one: every element is the last
      configure('0, '0);
      send_elem('0);
      send_elem(32'h8000_0000);
      drain();
      // oversized column count clamps to the line buffer depth
      configure(CsrDataW'(2), '1);
      send_elem(32'h5555_5555);
      send_elem(32'hAAAA_AAAA);
      send_elem(32'h0000_0001);
      drain();
      // shrink both sizes mid-matrix: element ends row and matrix
      configure(CsrDataW'(1), CsrDataW'(2));
      send_elem(32'hFFFF_FFFE);
      drain();
      write_csr(CsrSpare, '1);
      configure('1, CsrDataW'(1));
      send_elem(32'h0F0F_0F0F);
      send_elem(32'hF0F0_F0F0);
      send_elem(32'h7FFF_FFFF);
      drain();
      // row index already past the new last row
      configure(CsrDataW'(2), CsrDataW'(1));
      send_elem(32'h8000_0001);

      run_phase(14, 76, 430);
      run_phase(76, 14, 430);
      run_phase(0, 0, 430);

      drain();
      repeat (8) @(negedge clock);
      if (tracker.mismatches == 0 && tracker.awaited.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

### filelist.f
hw/rtl/mwr_pkg.sv
hw/rtl/mwr_queue.sv
hw/rtl/mwr_front.sv
hw/rtl/mwr_back.sv
hw/rtl/matrix_wavefront_recurrence_core.sv
tb/sv/tb_matrix_wavefront_recurrence_core.sv
